>>> rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared constants and elaboration-time table builders for the harmonic
// analyzer: twiddle entries and cordic step angles
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int MAX_H          = 5;
    localparam int NUM_HARMONICS  = 5;
    localparam int WINDOW_LENGTH  = 1191;
    localparam longint FUNDAMENTAL_HZ = 74;
    localparam longint SAMPLE_RATE_HZ = 88200;
    localparam longint PI4_Q30    = 843314857;
    localparam longint PI_Q32     = 64'sd13493037705;
    localparam int CORDIC_STEPS   = 24;
    localparam int SAMPLE_W       = 16;
    localparam int POW_W          = 60;
    localparam int ANG_W          = 16;
    localparam int TW_W           = 16;
    localparam int OUT_TDATA_W    = 384;
    localparam int ANG_BASE       = MAX_H * POW_W;
    localparam int HW             = $clog2(MAX_H + 1);

    // taylor term divisors (2k)(2k+1) and (2k-1)(2k) for k = 1..7
    localparam longint SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

    // odd divisors 2k+1 of the arctangent series
    localparam longint ODD_DIV [31] = '{
        1, 3, 5, 7, 9, 11, 13, 15, 17, 19, 21, 23, 25, 27, 29, 31,
        33, 35, 37, 39, 41, 43, 45, 47, 49, 51, 53, 55, 57, 59, 61
    };

    function automatic longint q30_to_q15(input longint v);
        longint t;
        t = (v < 0) ? 64'sd0 : v;
        t = (t + 64'sd16384) >>> 15;
        return (t > 64'sd32767) ? 64'sd32767 : t;
    endfunction

    // {nsin, cos} in q1.15 for harmonic h at window position n
    function automatic logic [2*TW_W-1:0] twiddle(input int h, input int n);
        longint a;
        longint e;
        longint r;
        longint m;
        longint x;
        longint x2;
        longint st;
        longint ct;
        longint s;
        longint c;
        longint cs;
        longint sn;
        longint rc;
        longint rs;
        longint nrs;
        int     q;
        a  = (longint'(h) * FUNDAMENTAL_HZ * longint'(n)) % SAMPLE_RATE_HZ;
        e  = 8 * a;
        q  = int'((e / SAMPLE_RATE_HZ) % 8);
        r  = e % SAMPLE_RATE_HZ;
        m  = (q % 2 == 1) ? SAMPLE_RATE_HZ - r : r;
        x  = (m * PI4_Q30) / SAMPLE_RATE_HZ;
        x2 = (x * x) >>> 30;
        st = x;
        ct = 64'sd1 <<< 30;
        s  = x;
        c  = 64'sd1 <<< 30;
        for (int k = 1; k <= 7; k++) begin
            st = ((st * x2) >>> 30) / SIN_DIV[k - 1];
            ct = ((ct * x2) >>> 30) / COS_DIV[k - 1];
            if (k % 2 == 1) begin
                s = s - st;
                c = c - ct;
            end else begin
                s = s + st;
                c = c + ct;
            end
        end
        cs = q30_to_q15(c);
        sn = q30_to_q15(s);
        unique case (q)
            0: begin rc = cs;  rs = sn;  end
            1: begin rc = sn;  rs = cs;  end
            2: begin rc = -sn; rs = cs;  end
            3: begin rc = -cs; rs = sn;  end
            4: begin rc = -cs; rs = -sn; end
            5: begin rc = -sn; rs = -cs; end
            6: begin rc = sn;  rs = -cs; end
            default: begin rc = cs; rs = -sn; end
        endcase
        nrs = -rs;
        return {nrs[TW_W-1:0], rc[TW_W-1:0]};
    endfunction

    // atan(2^-i) with pi = 2^29
    function automatic logic signed [31:0] atan_step(input int i);
        longint acc;
        longint t;
        int     k;
        acc = 0;
        k   = 0;
        if (i == 0) begin
            acc = 64'sd1 <<< 27;
        end else begin
            while (i * (2 * k + 1) <= 61) begin
                t = (64'sd1 <<< (61 - i * (2 * k + 1))) / ODD_DIV[k];
                acc = (k % 2 == 1) ? acc - t : acc + t;
                k++;
            end
            acc = acc / PI_Q32;
        end
        return acc[31:0];
    endfunction

endpackage

>>> rtl/core/sliding_harmonic_analyzer_unit.sv
// ----------------------------------------------------------------------------
// sliding_harmonic_analyzer_unit
// sliding-window dft over five harmonic bins with power and cordic phase
//
//   channel   dir  request holds
//   s_axis    in   sample [15:0]
//   m_axis    out  power_h1..h5 (60 b each), angle_h1..h5 (16 b each)
//
// the 24-step cordic is shared across the harmonics
// the sample window sits in a single-port ram, the sums in a small ram
// reset is synchronous, active low; the window reads as zero until filled
// a stalled result waits in the output register while the next sample runs
// ----------------------------------------------------------------------------
module sliding_harmonic_analyzer_unit #(
    parameter int WINDOW_LENGTH = sha_pkg::WINDOW_LENGTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sha_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // power_h1..power_h5, angle_h1..angle_h5, zero fill
    output logic [sha_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int N         = WINDOW_LENGTH;
    localparam int MAX_H     = sha_pkg::MAX_H;
    localparam int PW        = $clog2(N);
    localparam int ROM_DEPTH = MAX_H * N;
    localparam int RAW       = $clog2(ROM_DEPTH);
    localparam int SUM_W     = 34 + $clog2(N);
    localparam int HW        = sha_pkg::HW;
    localparam int TW_W      = sha_pkg::TW_W;
    localparam int POW_W     = sha_pkg::POW_W;
    localparam int ANG_W     = sha_pkg::ANG_W;
    localparam int SH_W      = SUM_W - 12;
    localparam logic [POW_W-1:0] POWER_MAX = '1;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_WIN  = 11'b000_0000_0010,
        ST_RD   = 11'b000_0000_0100,
        ST_MRE  = 11'b000_0000_1000,
        ST_MIM  = 11'b000_0001_0000,
        ST_SUM  = 11'b000_0010_0000,
        ST_PA   = 11'b000_0100_0000,
        ST_PB   = 11'b000_1000_0000,
        ST_PC   = 11'b001_0000_0000,
        ST_COR  = 11'b010_0000_0000,
        ST_DONE = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic signed [SUM_W-1:0] re;
        logic signed [SUM_W-1:0] im;
    } t_sums;

    // twiddle rom, built at elaboration
    logic [2*TW_W-1:0] w_rom [ROM_DEPTH];

    for (genvar gh = 0; gh < MAX_H; gh++) begin : g_h
        for (genvar gn = 0; gn < N; gn++) begin : g_n
            localparam logic [2*TW_W-1:0] TW_V = sha_pkg::twiddle(gh + 1, gn);
            assign w_rom[gh * N + gn] = TW_V;
        end
    end

    logic [sha_pkg::SAMPLE_W-1:0] r_win_mem [N];
    t_sums                        r_sum_mem [MAX_H];

    t_state                       r_state;
    logic [PW-1:0]                r_pos;
    logic                         r_full;
    logic [HW-1:0]                r_h;
    logic [RAW-1:0]               r_rom_addr;
    logic [MAX_H-1:0]             r_sum_vld;
    logic                         r_sum_vld_q;
    logic                         r_out_vld;
    logic                         r_cor_start;

    logic [sha_pkg::SAMPLE_W-1:0] r_sample;
    logic [sha_pkg::SAMPLE_W-1:0] r_win_q;
    logic [2*TW_W-1:0]            r_rom_q;
    t_sums                        r_sum_q;
    logic signed [16:0]           r_delta;
    logic signed [SUM_W-1:0]      r_re;
    logic signed [SUM_W-1:0]      r_im;
    logic signed [63:0]           r_prod;
    logic [POW_W-1:0]             r_pw;
    logic                         r_sat;
    logic [POW_W-1:0]             r_pow [MAX_H];
    logic [ANG_W-1:0]             r_ang [MAX_H];
    logic [sha_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic signed [31:0]           w_mul_a;
    logic signed [31:0]           w_mul_b;
    logic signed [SH_W-1:0]       w_sh;
    logic [SH_W-1:0]              w_abs;
    logic                         w_abs_sat;
    logic [POW_W:0]               w_psum;
    t_sums                        w_sum_old;
    logic                         w_accept;
    logic                         w_cor_done;
    logic [ANG_W-1:0]             w_cor_angle;
    logic [sha_pkg::OUT_TDATA_W-1:0] w_out_data;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign w_sum_old     = r_sum_vld_q ? r_sum_q : '0;

    // sums shifted right by 12, magnitude and range check
    always_comb begin
        w_sh      = (r_state == ST_PB) ? r_im[SUM_W-1:12] : r_re[SUM_W-1:12];
        w_abs     = w_sh[SH_W-1] ? SH_W'(-w_sh) : SH_W'(w_sh);
        w_abs_sat = (w_abs[SH_W-1:30] != '0);
    end

    always_comb begin
        unique case (r_state)
            ST_MRE: begin
                w_mul_a = 32'(r_delta);
                w_mul_b = 32'(signed'(r_rom_q[TW_W-1:0]));
            end
            ST_MIM: begin
                w_mul_a = 32'(r_delta);
                w_mul_b = 32'(signed'(r_rom_q[2*TW_W-1:TW_W]));
            end
            ST_PA, ST_PB: begin
                w_mul_a = {2'b00, w_abs[29:0]};
                w_mul_b = {2'b00, w_abs[29:0]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_psum = {1'b0, r_pw} + {1'b0, r_prod[POW_W-1:0]};

    always_comb begin
        w_out_data = '0;
        for (int h = 0; h < MAX_H; h++) begin
            if (h < sha_pkg::NUM_HARMONICS) begin
                w_out_data[h * POW_W +: POW_W] = r_pow[h];
                w_out_data[sha_pkg::ANG_BASE + h * ANG_W +: ANG_W] = r_ang[h];
            end
        end
    end

    sha_cordic #(
        .SUM_W (SUM_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_start),
        .i_re    (r_re),
        .i_im    (r_im),
        .o_done  (w_cor_done),
        .o_angle (w_cor_angle)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_full      <= 1'b0;
            r_h         <= '0;
            r_rom_addr  <= '0;
            r_sum_vld   <= '0;
            r_out_vld   <= 1'b0;
            r_cor_start <= 1'b0;
        end else begin
            r_cor_start <= (r_state == ST_PC);
            r_out_vld   <= ((r_state == ST_DONE) && (!r_out_vld || m_axis_tready))
                         || (r_out_vld && !m_axis_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state    <= ST_WIN;
                        r_h        <= '0;
                        r_rom_addr <= RAW'(r_pos);
                    end
                end
                ST_WIN:  r_state <= ST_RD;
                ST_RD:   r_state <= ST_MRE;
                ST_MRE:  r_state <= ST_MIM;
                ST_MIM:  r_state <= ST_SUM;
                ST_SUM: begin
                    r_state          <= ST_PA;
                    r_sum_vld[r_h[HW-1:0]] <= 1'b1;
                end
                ST_PA:   r_state <= ST_PB;
                ST_PB:   r_state <= ST_PC;
                ST_PC:   r_state <= ST_COR;
                ST_COR: begin
                    if (w_cor_done) begin
                        if (r_h == HW'(sha_pkg::NUM_HARMONICS - 1)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state    <= ST_RD;
                            r_h        <= r_h + 1'b1;
                            r_rom_addr <= r_rom_addr + RAW'(N);
                        end
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_state   <= ST_IDLE;
                        if (r_pos == PW'(N - 1)) begin
                            r_pos  <= '0;
                            r_full <= 1'b1;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win_q <= r_win_mem[r_pos];
        end
        if (r_state == ST_WIN) begin
            r_win_mem[r_pos] <= r_sample;
        end
        r_rom_q     <= w_rom[r_rom_addr];
        r_sum_q     <= r_sum_mem[r_h];
        r_sum_vld_q <= r_sum_vld[r_h];
        if (r_state == ST_SUM) begin
            r_sum_mem[r_h] <= '{re: r_re, im: w_sum_old.im + r_prod[SUM_W-1:0]};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_accept) begin
            r_sample <= s_axis_tdata;
        end
        if (r_state == ST_WIN) begin
            r_delta <= signed'({1'b0, r_sample})
                     - signed'({1'b0, (r_full ? r_win_q : 16'h0000)});
        end
        if (r_state == ST_MIM) begin
            r_re <= w_sum_old.re + r_prod[SUM_W-1:0];
        end
        if (r_state == ST_SUM) begin
            r_im <= w_sum_old.im + r_prod[SUM_W-1:0];
        end
        if (r_state == ST_PA) begin
            r_sat <= w_abs_sat;
        end
        if (r_state == ST_PB) begin
            r_sat <= r_sat || w_abs_sat;
            r_pw  <= r_prod[POW_W-1:0];
        end
        if (r_state == ST_PC) begin
            r_pow[r_h] <= (r_sat || w_psum[POW_W]) ? POWER_MAX : w_psum[POW_W-1:0];
        end
        if ((r_state == ST_COR) && w_cor_done) begin
            r_ang[r_h] <= w_cor_angle;
        end
        if ((r_state == ST_DONE) && (!r_out_vld || m_axis_tready)) begin
            r_out_data <= w_out_data;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_WIN))
        else $error("accepted request did not start window update");
    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_h < HW'(MAX_H))
        else $error("harmonic index out of range");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(N - 1))
        else $error("window position out of range");
    a_cor_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cor_done |-> (r_state == ST_COR))
        else $error("cordic finished outside its state");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside done state");
`endif

endmodule

>>> rtl/core/sha_cordic.sv
// ----------------------------------------------------------------------------
// sha_cordic
// iterative vectoring cordic, one step per cycle, returns the phase of a
// complex sum in 16-bit turn units
// ----------------------------------------------------------------------------
module sha_cordic #(
    parameter int SUM_W = 45
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SUM_W-1:0]  i_re,
    input  logic signed [SUM_W-1:0]  i_im,
    output logic                     o_done,
    output logic [sha_pkg::ANG_W-1:0] o_angle
);

    localparam int CW    = SUM_W + 2;
    localparam int STEPS = sha_pkg::CORDIC_STEPS;
    localparam int IW    = $clog2(STEPS);

    logic signed [31:0] w_atan [STEPS];

    for (genvar gi = 0; gi < STEPS; gi++) begin : g_atan
        localparam logic signed [31:0] ATAN_V = sha_pkg::atan_step(gi);
        assign w_atan[gi] = ATAN_V;
    end

    logic              r_busy;
    logic              r_done;
    logic [IW-1:0]     r_i;
    logic              r_zero;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [31:0]   r_z;

    logic signed [CW-1:0] w_re;
    logic signed [CW-1:0] w_im;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [31:0]   w_zr;

    assign w_re = {{2{i_re[SUM_W-1]}}, i_re};
    assign w_im = {{2{i_im[SUM_W-1]}}, i_im};
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_zr = r_z + 32'sd8192;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_busy && (r_i == IW'(STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_re == '0) && (i_im == '0);
            if (w_re[CW-1]) begin
                if (!w_im[CW-1]) begin
                    r_x <= w_im;
                    r_y <= -w_re;
                    r_z <= 32'sd268435456;
                end else begin
                    r_x <= -w_im;
                    r_y <= w_re;
                    r_z <= -32'sd268435456;
                end
            end else begin
                r_x <= w_re;
                r_y <= w_im;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan[r_i];
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan[r_i];
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : w_zr[29:14];

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("cordic started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("cordic done without run");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("cordic done while busy");
`endif

endmodule
